FILE: rtl/bpnp_pkg.sv
package bpnp_pkg;

   localparam int MAX_POINTS = 64;
   localparam int SAMPLES    = 24;

   localparam int COORD_W = 24;
   localparam int FRAC_W  = 16;
   localparam int CTRL_W  = COORD_W + 1;
   localparam int WGT_W   = FRAC_W + 1;
   localparam int PROD_W  = CTRL_W + WGT_W + 1;
   localparam int TERM_W  = PROD_W - FRAC_W;
   localparam int SUM_W   = TERM_W + 2;
   localparam int DIFF_W  = SUM_W + 1;
   localparam int SQ_W    = 2 * DIFF_W - 1;
   localparam int D2_W    = SQ_W + 1;

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int STEP_W = $clog2(SAMPLES + 1);

   localparam int SEG_W  = 6;
   localparam int SSTEP_W = 5;
   localparam int DIST_W = 25;

   localparam int IN_DATA_W  = 6 * COORD_W;
   localparam int IN_USER_W  = 2;
   localparam int OUT_FLD_W  = SEG_W + SSTEP_W + DIST_W;
   localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

   typedef enum logic {
      CMD_APPEND = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   // ax sits in the lowest bits
   typedef struct packed {
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] ax;
   } point_type;

   typedef logic [SAMPLES:0][3:0][WGT_W-1:0] wrom_type;

   localparam longint unsigned WDEN  = longint'(SAMPLES) * SAMPLES * SAMPLES;
   localparam longint unsigned WDEN2 = 2 * WDEN;
   localparam longint unsigned WNUM_SCALE = longint'(1) << (FRAC_W + 1);

   // Bernstein weights, Q1.16, rounded half up
   function automatic wrom_type build_wrom();
      wrom_type rom;
      longint unsigned t;
      longint unsigned u;
      for (int s = 0; s <= SAMPLES; s++) begin
         t = longint'(s);
         u = longint'(SAMPLES) - t;
         rom[s][0] = WGT_W'((u * u * u * WNUM_SCALE + WDEN) / WDEN2);
         rom[s][1] = WGT_W'((3 * u * u * t * WNUM_SCALE + WDEN) / WDEN2);
         rom[s][2] = WGT_W'((3 * u * t * t * WNUM_SCALE + WDEN) / WDEN2);
         rom[s][3] = WGT_W'((t * t * t * WNUM_SCALE + WDEN) / WDEN2);
      end
      return rom;
   endfunction

   localparam wrom_type W_ROM = build_wrom();

endpackage

FILE: rtl/bezier_path_nearest_point_top.sv
// Closed cubic Bezier path, nearest point by sampling. An append word (tuser[0] = 0) stores
// one anchor with its in- and out-handle offsets; tuser[1] = 1 empties the path first,
// appends beyond 64 points are dropped. A query word (tuser[0] = 1) walks every edge of
// the path, the closing edge included, at 25 parameter steps, and returns the earliest
// sample with the smallest distance: edge index, step and floor square root of the squared
// distance, saturated to 25 bits; rsp_tuser is 0 when the path holds fewer than two points.
// One evaluator pipeline takes one sample per cycle while it walks an edge; between edges it
// waits for the point memory read and the control point setup. The distance comes from a
// bit-serial square root; a query on a path of fewer than two points goes straight to the
// result. A new word is accepted while a result waits.
module bezier_path_nearest_point_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // px, py, handle_in_x, handle_in_y, handle_out_x, handle_out_y
   input  logic [bpnp_pkg::IN_DATA_W-1:0]     req_tdata,
   // cmd, restart
   input  logic [bpnp_pkg::IN_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // segment, sample_step, dist_res, zero pad
   output logic [bpnp_pkg::OUT_DATA_W-1:0]    rsp_tdata,
   // found
   output logic                               rsp_tuser
);
   import bpnp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SAMPLE,
      ST_DRAIN,
      ST_SQRT,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic [CNT_W-1:0]          point_count_ff;
   point_type                 pmem [MAX_POINTS];
   point_type                 rd_a_ff;
   point_type                 rd_b_ff;

   logic [ADDR_W-1:0]         edge_ff;
   logic [ADDR_W-1:0]         last_ff;
   logic [ADDR_W-1:0]         next_edge;
   logic [STEP_W-1:0]         step_ff;
   logic signed [COORD_W-1:0] qx_ff;
   logic signed [COORD_W-1:0] qy_ff;
   logic signed [CTRL_W-1:0]  cx_ff [4];
   logic signed [CTRL_W-1:0]  cy_ff [4];

   logic                      v1_ff;
   logic                      v2_ff;
   logic                      v3_ff;
   logic signed [PROD_W-1:0]  prodx_ff [4];
   logic signed [PROD_W-1:0]  prody_ff [4];
   logic signed [PROD_W-1:0]  prodx_in [4];
   logic signed [PROD_W-1:0]  prody_in [4];
   logic [ADDR_W-1:0]         seg1_ff, seg2_ff, seg3_ff;
   logic [STEP_W-1:0]         step1_ff, step2_ff, step3_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]           sqx_ff, sqy_ff;
   logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
   logic [D2_W-1:0]           d2_in;

   logic                      have_ff;
   logic                      found_ff;
   logic [D2_W-1:0]           best_ff;
   logic [ADDR_W-1:0]         best_seg_ff;
   logic [STEP_W-1:0]         best_step_ff;

   logic [D2_W-1:0]           rad_ff, root_ff, bit_ff;
   logic [D2_W-1:0]           trial;
   logic [D2_W-1:0]           rad_in, root_in;
   logic [DIST_W-1:0]         dist_in;

   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [SEG_W-1:0]          rsp_seg_ff;
   logic [SSTEP_W-1:0]        rsp_step_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;

   logic                      req_acc;
   cmd_type                   req_cmd;
   logic                      req_restart;
   point_type                 req_pt;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic                      rsp_free;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_acc     = req_tvalid && req_tready;
   assign req_cmd     = cmd_type'(req_tuser[0]);
   assign req_restart = req_tuser[1];
   assign req_pt      = point_type'(req_tdata);
   assign wr_en       = req_acc && (req_cmd == CMD_APPEND)
                        && (req_restart || (point_count_ff < CNT_W'(MAX_POINTS)));
   assign wr_addr     = req_restart ? '0 : point_count_ff[ADDR_W-1:0];
   assign next_edge   = (edge_ff == last_ff) ? '0 : edge_ff + 1'b1;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;

   // point memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pmem[wr_addr] <= req_pt;
      end
      rd_a_ff <= pmem[edge_ff];
      rd_b_ff <= pmem[next_edge];
   end

   // evaluator datapath
   always_comb begin
      logic signed [WGT_W:0]    w_s;
      logic signed [TERM_W-1:0] tx;
      logic signed [TERM_W-1:0] ty;
      logic signed [SUM_W-1:0]  sx;
      logic signed [SUM_W-1:0]  sy;
      sx = '0;
      sy = '0;
      for (int k = 0; k < 4; k++) begin
         w_s         = {1'b0, W_ROM[step_ff][k]};
         prodx_in[k] = w_s * cx_ff[k];
         prody_in[k] = w_s * cy_ff[k];
         tx          = prodx_ff[k][PROD_W-1:FRAC_W];
         ty          = prody_ff[k][PROD_W-1:FRAC_W];
         sx          = sx + SUM_W'(tx);
         sy          = sy + SUM_W'(ty);
      end
      dx_in    = DIFF_W'(sx) - DIFF_W'(qx_ff);
      dy_in    = DIFF_W'(sy) - DIFF_W'(qy_ff);
      sqx_full = dx_ff * dx_ff;
      sqy_full = dy_ff * dy_ff;
      d2_in    = D2_W'(sqx_ff) + D2_W'(sqy_ff);
   end

   // square root step
   always_comb begin
      trial = root_ff + bit_ff;
      if (rad_ff >= trial) begin
         rad_in  = rad_ff - trial;
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         rad_in  = rad_ff;
         root_in = root_ff >> 1;
      end
      if (|root_ff[D2_W-1:DIST_W]) begin
         dist_in = '1;
      end else begin
         dist_in = root_ff[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= '0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         have_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         v1_ff <= (state_ff == ST_SAMPLE);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (v3_ff && (!have_ff || d2_in < best_ff)) begin
            have_ff      <= 1'b1;
            best_ff      <= d2_in;
            best_seg_ff  <= seg3_ff;
            best_step_ff <= step3_ff;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_cmd == CMD_APPEND) begin
                     if (req_restart) begin
                        point_count_ff <= CNT_W'(1);
                     end else if (point_count_ff < CNT_W'(MAX_POINTS)) begin
                        point_count_ff <= point_count_ff + 1'b1;
                     end
                  end else begin
                     qx_ff   <= req_pt.ax;
                     qy_ff   <= req_pt.ay;
                     have_ff <= 1'b0;
                     edge_ff <= '0;
                     last_ff <= ADDR_W'(point_count_ff - 1'b1);
                     if (point_count_ff < CNT_W'(2)) begin
                        found_ff     <= 1'b0;
                        root_ff      <= '0;
                        best_seg_ff  <= '0;
                        best_step_ff <= '0;
                        state_ff     <= ST_DONE;
                     end else begin
                        found_ff <= 1'b1;
                        state_ff <= ST_READ;
                     end
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               cx_ff[0] <= CTRL_W'(rd_a_ff.ax);
               cy_ff[0] <= CTRL_W'(rd_a_ff.ay);
               cx_ff[1] <= CTRL_W'(rd_a_ff.ax) + CTRL_W'(rd_a_ff.out_x);
               cy_ff[1] <= CTRL_W'(rd_a_ff.ay) + CTRL_W'(rd_a_ff.out_y);
               cx_ff[2] <= CTRL_W'(rd_b_ff.ax) + CTRL_W'(rd_b_ff.in_x);
               cy_ff[2] <= CTRL_W'(rd_b_ff.ay) + CTRL_W'(rd_b_ff.in_y);
               cx_ff[3] <= CTRL_W'(rd_b_ff.ax);
               cy_ff[3] <= CTRL_W'(rd_b_ff.ay);
               step_ff  <= '0;
               state_ff <= ST_SAMPLE;
            end
            ST_SAMPLE: begin
               if (step_ff == STEP_W'(SAMPLES)) begin
                  if (edge_ff == last_ff) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     edge_ff  <= edge_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               if (!v1_ff && !v2_ff && !v3_ff) begin
                  rad_ff   <= best_ff;
                  root_ff  <= '0;
                  bit_ff   <= D2_W'(1) << (D2_W - 2);
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               rad_ff  <= rad_in;
               root_ff <= root_in;
               bit_ff  <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_found_ff <= found_ff;
                  rsp_seg_ff   <= SEG_W'(best_seg_ff);
                  rsp_step_ff  <= SSTEP_W'(best_step_ff);
                  rsp_dist_ff  <= dist_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         prodx_ff[k] <= prodx_in[k];
         prody_ff[k] <= prody_in[k];
      end
      seg1_ff  <= edge_ff;
      step1_ff <= step_ff;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      seg2_ff  <= seg1_ff;
      step2_ff <= step1_ff;
      sqx_ff   <= sqx_full[SQ_W-1:0];
      sqy_ff   <= sqy_full[SQ_W-1:0];
      seg3_ff  <= seg2_ff;
      step3_ff <= step2_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {(OUT_DATA_W - OUT_FLD_W)'(0), rsp_dist_ff, rsp_step_ff, rsp_seg_ff};

   a_drained_before_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> (!v1_ff && !v2_ff && !v3_ff))
      else $error("sample pipeline not empty at square root");

   a_edge_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SAMPLE) |-> (edge_ff <= last_ff && step_ff <= STEP_W'(SAMPLES)))
      else $error("edge or step beyond path");

   a_found_has_best: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && found_ff) |-> have_ff)
      else $error("result without a sampled minimum");

endmodule

FILE: tb/sv/tb_bezier_path_nearest_point_top.sv
module tb_bezier_path_nearest_point_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpnp_pkg::*;

   localparam int WORDS_TARGET = 360;
   localparam int IDLE_PCT     = 13;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 64;
   localparam longint DIST_SAT = 33554431;

   localparam logic signed [COORD_W-1:0] ONE   = 24'sh010000;
   localparam logic signed [COORD_W-1:0] THREE = 24'sh030000;
   localparam logic signed [COORD_W-1:0] MONE  = 24'shFF0000;
   localparam logic signed [COORD_W-1:0] TWO   = 24'sh020000;
   localparam logic signed [COORD_W-1:0] MTWO  = 24'shFE0000;
   localparam logic signed [COORD_W-1:0] CMAX  = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] CMIN  = 24'sh800000;
   localparam logic signed [COORD_W-1:0] PAT5  = 24'sh555555;
   localparam logic signed [COORD_W-1:0] PATA  = 24'shAAAAAA;

   typedef struct packed {
      logic        found;
      logic [5:0]  seg;
      logic [4:0]  step;
      logic [24:0] dres;
   } nearest_hit;

   typedef struct packed {
      cmd_type    cmd;
      logic       restart;
      point_type  pt;
      logic       known;
      nearest_hit hit;
   } plan_row;

   localparam nearest_hit NOT_FOUND = '0;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata  = '0;
   logic [IN_USER_W-1:0]  req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   bezier_path_nearest_point_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // path model
   longint bern [SAMPLES+1][4];
   longint path_ax [MAX_POINTS];
   longint path_ay [MAX_POINTS];
   longint path_ix [MAX_POINTS];
   longint path_iy [MAX_POINTS];
   longint path_ox [MAX_POINTS];
   longint path_oy [MAX_POINTS];
   int     path_len = 0;

   nearest_hit hits_due [$];
   nearest_hit pinned_hit = '0;
   bit         pinned = 1'b0;
   nearest_hit got_hit, want_hit, calc_hit;

   int  errors = 0, sent = 0, words_in = 0, quiet = 0;
   int  n_append = 0, n_query = 0, n_full = 0, n_checked = 0, n_missing = 0;
   bit  held = 1'b0;
   logic calm;

   assign calm = (words_in >= 200) && (words_in < 280);

   function automatic bit path_word(input cmd_type cmd, input logic restart,
                                    input point_type pt, output nearest_hit hit);
      longint qx, qy, bx, by, dx, dy, d2, best, root, trial;
      longint cx [4];
      longint cy [4];
      int j;
      bit have;
      hit = '0;
      if (cmd == CMD_APPEND) begin
         if (restart) path_len = 0;
         if (path_len < MAX_POINTS) begin
            path_ax[path_len] = pt.ax;
            path_ay[path_len] = pt.ay;
            path_ix[path_len] = pt.in_x;
            path_iy[path_len] = pt.in_y;
            path_ox[path_len] = pt.out_x;
            path_oy[path_len] = pt.out_y;
            path_len++;
         end
         return 1'b0;
      end
      if (path_len < 2) return 1'b1;
      qx = pt.ax;
      qy = pt.ay;
      have = 1'b0;
      best = 0;
      for (int i = 0; i < path_len; i++) begin
         j = (i + 1 == path_len) ? 0 : i + 1;
         cx[0] = path_ax[i];
         cy[0] = path_ay[i];
         cx[1] = path_ax[i] + path_ox[i];
         cy[1] = path_ay[i] + path_oy[i];
         cx[2] = path_ax[j] + path_ix[j];
         cy[2] = path_ay[j] + path_iy[j];
         cx[3] = path_ax[j];
         cy[3] = path_ay[j];
         for (int s = 0; s <= SAMPLES; s++) begin
            bx = 0;
            by = 0;
            for (int k = 0; k < 4; k++) begin
               bx += (bern[s][k] * cx[k]) >>> 16;
               by += (bern[s][k] * cy[k]) >>> 16;
            end
            dx = bx - qx;
            dy = by - qy;
            d2 = dx * dx + dy * dy;
            if (!have || d2 < best) begin
               have = 1'b1;
               best = d2;
               hit.seg = 6'(i);
               hit.step = 5'(s);
            end
         end
      end
      root = 0;
      for (int b = 27; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= best) root = trial;
      end
      hit.found = 1'b1;
      hit.dres = 25'((root > DIST_SAT) ? DIST_SAT : root);
      return 1'b1;
   endfunction

   function automatic plan_row row(input cmd_type c, input logic r,
                                   input logic signed [COORD_W-1:0] ax, ay, ix, iy, ox, oy,
                                   input logic known, input nearest_hit hit);
      plan_row p;
      p.cmd = c;
      p.restart = r;
      p.pt = '{out_y: oy, out_x: ox, in_y: iy, in_x: ix, ay: ay, ax: ax};
      p.known = known;
      p.hit = hit;
      return p;
   endfunction

   function automatic logic signed [COORD_W-1:0] rnd_coord();
      case ($urandom_range(4))
         0: return COORD_W'($urandom);
         1: return $urandom_range(1) ? CMAX : CMIN;
         2: return COORD_W'(int'($urandom_range(128 * 65536)) - 64 * 65536);
         default: return COORD_W'(int'($urandom_range(8 * 65536)) - 4 * 65536);
      endcase
   endfunction

   function automatic point_type rnd_point();
      point_type p;
      p.ax = rnd_coord();
      p.ay = rnd_coord();
      p.in_x = rnd_coord();
      p.in_y = rnd_coord();
      p.out_x = rnd_coord();
      p.out_y = rnd_coord();
      return p;
   endfunction

   task automatic offer(input cmd_type cmd, input logic restart, input point_type pt,
                        input bit pin, input nearest_hit pin_hit);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      pinned = pin;
      pinned_hit = pin_hit;
      req_tvalid <= 1'b1;
      req_tuser <= {restart, cmd};
      req_tdata <= pt;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      sent++;
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (hits_due.size() != 0) @(posedge clock);
   endtask

   // handshakes are judged at the falling edge ahead of the rising edge that takes them
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_hit = {rsp_tuser, rsp_tdata[5:0], rsp_tdata[10:6], rsp_tdata[35:11]};
            if (hits_due.size() == 0) begin
               errors++;
               $error("result word with no query pending");
            end else begin
               want_hit = hits_due.pop_front();
               n_checked++;
               if (!want_hit.found) n_missing++;
               if (got_hit.found !== want_hit.found) begin
                  errors++;
                  $error("found: expected %0d, got %0d", want_hit.found, got_hit.found);
               end
               if (got_hit.seg !== want_hit.seg) begin
                  errors++;
                  $error("segment: expected %0d, got %0d", want_hit.seg, got_hit.seg);
               end
               if (got_hit.step !== want_hit.step) begin
                  errors++;
                  $error("sample_step: expected %0d, got %0d", want_hit.step, got_hit.step);
               end
               if (got_hit.dres !== want_hit.dres) begin
                  errors++;
                  $error("dist_res: expected %0d, got %0d", want_hit.dres, got_hit.dres);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (cmd_type'(req_tuser[0]) == CMD_QUERY) begin
               n_query++;
               if (path_len == MAX_POINTS) n_full++;
            end else begin
               n_append++;
            end
            if (path_word(cmd_type'(req_tuser[0]), req_tuser[1], point_type'(req_tdata),
                          calc_hit))
               hits_due = {hits_due, (pinned ? pinned_hit : calc_hit)};
            words_in++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
               $display("timeout: %0d results still due", hits_due.size());
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held && words_in >= 120) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      plan_row   plan [23];
      longint    u, t, den;
      int        seq, len, nq, idx;
      bit        full;
      point_type pt;

      den = longint'(SAMPLES) * SAMPLES * SAMPLES;
      for (int s = 0; s <= SAMPLES; s++) begin
         t = s;
         u = SAMPLES - s;
         bern[s][0] = (u * u * u * 131072 + den) / (2 * den);
         bern[s][1] = (3 * u * u * t * 131072 + den) / (2 * den);
         bern[s][2] = (3 * u * t * t * 131072 + den) / (2 * den);
         bern[s][3] = (t * t * t * 131072 + den) / (2 * den);
      end

      plan = '{
         row(CMD_QUERY,  1'b0, 0, 0, 0, 0, 0, 0, 1'b1, NOT_FOUND),
         row(CMD_QUERY,  1'b1, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1'b1, NOT_FOUND),
         row(CMD_APPEND, 1'b1, 0, 0, 0, 0, 0, 0, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b0, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 1'b1, NOT_FOUND),
         row(CMD_APPEND, 1'b0, ONE, 0, 0, 0, 0, 0, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b0, 0, 0, 0, 0, 0, 0, 1'b1, nearest_hit'({1'b1, 6'd0, 5'd0, 25'd0})),
         row(CMD_QUERY,  1'b0, ONE, 0, 0, 0, 0, 0, 1'b1,
             nearest_hit'({1'b1, 6'd0, 5'd24, 25'd0})),
         row(CMD_QUERY,  1'b0, 0, THREE, 0, 0, 0, 0, 1'b1,
             nearest_hit'({1'b1, 6'd0, 5'd0, 25'd196608})),
         row(CMD_QUERY,  1'b0, CMAX, CMIN, 0, 0, 0, 0, 1'b0, NOT_FOUND),
         row(CMD_APPEND, 1'b1, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b0, NOT_FOUND),
         row(CMD_APPEND, 1'b0, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b0, CMAX, CMAX, 0, 0, 0, 0, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b0, CMIN, CMIN, 0, 0, 0, 0, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b1, 0, 0, CMAX, CMAX, CMAX, CMAX, 1'b0, NOT_FOUND),
         row(CMD_APPEND, 1'b0, PAT5, PATA, PATA, PAT5, PAT5, PATA, 1'b0, NOT_FOUND),
         row(CMD_APPEND, 1'b0, PATA, PAT5, PAT5, PATA, PATA, PAT5, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b0, 0, 0, 0, 0, 0, 0, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b0, 24'sh123456, 24'shEDCBA9, 0, 0, 0, 0, 1'b0, NOT_FOUND),
         row(CMD_APPEND, 1'b1, ONE, ONE, 0, 0, 0, 0, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b0, ONE, ONE, 0, 0, 0, 0, 1'b1, NOT_FOUND),
         row(CMD_APPEND, 1'b0, MONE, MONE, 0, TWO, 0, MTWO, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b0, 0, 0, 0, 0, 0, 0, 1'b0, NOT_FOUND),
         row(CMD_QUERY,  1'b0, MONE, ONE, 0, 0, 0, 0, 1'b0, NOT_FOUND)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) offer(plan[r].cmd, plan[r].restart, plan[r].pt, plan[r].known,
                              plan[r].hit);
      wait_results();

      seq = 0;
      while (sent < WORDS_TARGET) begin
         full = (seq == 4) || (seq == 14);
         if (full) wait_results();
         if (full || $urandom_range(99) < 85) begin
            if (full) len = MAX_POINTS + 2;
            else if ($urandom_range(9) == 0) len = 1;
            else len = $urandom_range(7, 2);
            for (int k = 0; k < len; k++) offer(CMD_APPEND, k == 0, rnd_point(), 1'b0, '0);
            nq = $urandom_range(3, 1);
            for (int q = 0; q < nq; q++) begin
               pt = rnd_point();
               if (path_len != 0 && $urandom_range(3) != 0) begin
                  idx = $urandom_range(path_len - 1);
                  pt.ax = COORD_W'(path_ax[idx] + longint'($urandom_range(2 * 65536)) - 65536);
                  pt.ay = COORD_W'(path_ay[idx] + longint'($urandom_range(2 * 65536)) - 65536);
               end
               offer(CMD_QUERY, $urandom_range(1), pt, 1'b0, '0);
            end
         end else begin
            repeat ($urandom_range(4, 1))
               offer(cmd_type'($urandom_range(1)), $urandom_range(3) == 0, rnd_point(),
                     1'b0, '0);
         end
         seq++;
      end

      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d words: %0d appends, %0d queries (%0d on a full path, %0d on short paths)",
               words_in, n_append, n_query, n_full, n_missing);
      $display("%0d results compared, %0d mismatches", n_checked, errors);
      if (errors == 0 && hits_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/bpnp_pkg.sv
rtl/bezier_path_nearest_point_top.sv
tb/sv/tb_bezier_path_nearest_point_top.sv
